/* rtl/core/rmte_pkg.sv */
// rmte_pkg: shared types, constants and the cordic angle table
// for the rotation matrix to euler angles core; no dependencies
package rmte_pkg;

    localparam int TABLE_LEN = 24;
    localparam int SQ_STEPS  = 25;
    localparam int XW        = 30;
    localparam int ZW        = 29;

    localparam logic signed [ZW-1:0] PI_Q24      = 29'sd52707179;
    localparam logic signed [17:0]   PI_Q13      = 18'sd25736;
    localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;

    localparam logic [1:0] POLE_NONE  = 2'd0;
    localparam logic [1:0] POLE_NORTH = 2'd1;
    localparam logic [1:0] POLE_SOUTH = 2'd2;

    localparam logic REG_HANDEDNESS = 1'b0;
    localparam logic REG_THRESHOLD  = 1'b1;

    localparam logic [14:0] THRESHOLD_RESET = 15'd16351;

    typedef struct packed {
        logic signed [16:0] ay;
        logic signed [16:0] ax;
        logic signed [16:0] cy;
        logic signed [16:0] cx;
        logic signed [15:0] v;
        logic               sat;
        logic [1:0]         pole;
        logic               hand;
    } item_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    typedef struct packed {
        lane_t              a;
        lane_t              b;
        lane_t              c;
        logic               zero_a;
        logic               zero_c;
        logic               sat;
        logic signed [15:0] v;
        logic [1:0]         pole;
        logic               hand;
    } crd_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        unique case (i)
            0:  r = 29'sd13176795;
            1:  r = 29'sd7778716;
            2:  r = 29'sd4110060;
            3:  r = 29'sd2086331;
            4:  r = 29'sd1047214;
            5:  r = 29'sd524117;
            6:  r = 29'sd262123;
            7:  r = 29'sd131069;
            8:  r = 29'sd65536;
            9:  r = 29'sd32768;
            10: r = 29'sd16384;
            11: r = 29'sd8192;
            12: r = 29'sd4096;
            13: r = 29'sd2048;
            14: r = 29'sd1024;
            15: r = 29'sd512;
            16: r = 29'sd256;
            17: r = 29'sd128;
            18: r = 29'sd64;
            19: r = 29'sd32;
            20: r = 29'sd16;
            21: r = 29'sd8;
            22: r = 29'sd4;
            23: r = 29'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // one vectoring step, rotating toward y = 0
    function automatic lane_t cordic_step(input lane_t l, input int i);
        lane_t o;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        dx = l.y >>> i;
        dy = l.x >>> i;
        if (!l.y[XW-1])
        begin
            o.x = l.x + dx;
            o.y = l.y - dy;
            o.z = l.z + atan_entry(i);
        end
        else
        begin
            o.x = l.x - dx;
            o.y = l.y + dy;
            o.z = l.z - atan_entry(i);
        end
        return o;
    endfunction

    // quadrant fold for x < 0, operands scaled by 2^10
    function automatic lane_t cordic_init(input logic signed [16:0] y,
                                          input logic signed [16:0] x);
        lane_t o;
        logic signed [XW-1:0] ys;
        logic signed [XW-1:0] xs;
        ys = {{(XW-27){y[16]}}, y, 10'd0};
        xs = {{(XW-27){x[16]}}, x, 10'd0};
        if (x[16])
        begin
            o.x = -xs;
            o.y = -ys;
            o.z = y[16] ? -PI_Q24 : PI_Q24;
        end
        else
        begin
            o.x = xs;
            o.y = ys;
            o.z = '0;
        end
        return o;
    endfunction

    // round to q2.13 and clamp to +/-pi
    function automatic logic signed [15:0] round_angle(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] t;
        logic signed [17:0]   r;
        t = z + 29'sd1024;
        r = 18'(t >>> 11);
        if (r > PI_Q13)
            r = PI_Q13;
        else if (r < -PI_Q13)
            r = -PI_Q13;
        return r[15:0];
    endfunction

endpackage

/* rtl/core/rotation_matrix_to_euler_angles_core.sv */
// rotation_matrix_to_euler_angles_core: rotation matrix to euler angles,
// pipelined square root and three cordic lanes; depends on rmte_pkg
// throughput: one beat per cycle, busy is tied low, no stall on either side
// the pipe is an entry register, the 25 square root steps, a cordic entry
// register, the cordic stages and an output register
// reset: async active low clears valid bits and config (threshold 16351)
module rotation_matrix_to_euler_angles_core
    import rmte_pkg::*;
#(
    parameter int CORDIC_STAGES = 14
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [14:0]        wr_data,
    input  logic signed [15:0] m11,
    input  logic signed [15:0] m13,
    input  logic signed [15:0] m21,
    input  logic signed [15:0] m22,
    input  logic signed [15:0] m23,
    input  logic signed [15:0] m31,
    input  logic signed [15:0] m33,
    output logic               done,
    output logic signed [15:0] angle_first,
    output logic signed [15:0] angle_second,
    output logic signed [15:0] angle_third,
    output logic [1:0]         pole_case
);

    localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int LAT  = NSTG + 28;

    logic        hand_reg;
    logic [14:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hand_reg <= 1'b0;
            thr_reg  <= THRESHOLD_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_HANDEDNESS: hand_reg <= wr_data[0];
                REG_THRESHOLD:  thr_reg  <= wr_data;
                default:        ;
            endcase
        end
    end

    assign busy = 1'b0;

    // entry stage: pole decision, operand select, asin radicand
    logic               accept;
    logic signed [16:0] thr_s;
    logic signed [16:0] v17;
    logic               north;
    logic               south;
    logic signed [31:0] sq;
    logic [28:0]        rad;
    item_t              item_next;
    logic [49:0]        n_next;

    assign accept = start && !busy;

    always_comb
    begin
        thr_s = {2'b00, thr_reg};
        v17   = {m21[15], m21};
        north = v17 > thr_s;
        south = v17 < -thr_s;
        sq    = m21 * m21;
        item_next.v    = m21;
        item_next.sat  = (m21 >= 16'sd16384) || (m21 <= -16'sd16384);
        item_next.hand = hand_reg;
        item_next.pole = north ? POLE_NORTH : (south ? POLE_SOUTH : POLE_NONE);
        if (north || south)
        begin
            item_next.ay = {m13[15], m13};
            item_next.ax = {m33[15], m33};
        end
        else
        begin
            item_next.ay = -{m31[15], m31};
            item_next.ax = {m11[15], m11};
        end
        item_next.cy = -{m23[15], m23};
        item_next.cx = {m22[15], m22};
        rad    = item_next.sat ? 29'd0 : 29'(32'sd268435456 - sq);
        n_next = {1'b0, rad, 20'd0};
    end

    logic [SQ_STEPS:0] sq_vld_reg;
    item_t             sq_item_reg [SQ_STEPS+1];
    logic [49:0]       sq_n_reg    [SQ_STEPS+1];
    logic [49:0]       sq_res_reg  [SQ_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else
            sq_vld_reg[0] <= accept;
    end

    always_ff @(posedge clk)
    begin
        sq_item_reg[0] <= item_next;
        sq_n_reg[0]    <= n_next;
        sq_res_reg[0]  <= '0;
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [49:0] BIT = 50'd1 << (2 * (SQ_STEPS - 1 - k));
        logic [49:0] trial;
        assign trial = sq_res_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k+1] <= 1'b0;
            else
                sq_vld_reg[k+1] <= sq_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            sq_item_reg[k+1] <= sq_item_reg[k];
            if (sq_n_reg[k] >= trial)
            begin
                sq_n_reg[k+1]   <= sq_n_reg[k] - trial;
                sq_res_reg[k+1] <= (sq_res_reg[k] >> 1) + BIT;
            end
            else
            begin
                sq_n_reg[k+1]   <= sq_n_reg[k];
                sq_res_reg[k+1] <= sq_res_reg[k] >> 1;
            end
        end
    end

    // cordic entry
    item_t it;
    crd_t  crd_next;
    assign it = sq_item_reg[SQ_STEPS];

    always_comb
    begin
        crd_next.a      = cordic_init(it.ay, it.ax);
        crd_next.c      = cordic_init(it.cy, it.cx);
        crd_next.b.x    = {{(XW-25){1'b0}}, sq_res_reg[SQ_STEPS][24:0]};
        crd_next.b.y    = {{(XW-26){it.v[15]}}, it.v, 10'd0};
        crd_next.b.z    = '0;
        crd_next.zero_a = (it.ay == '0) && (it.ax == '0);
        crd_next.zero_c = (it.cy == '0) && (it.cx == '0);
        crd_next.sat    = it.sat;
        crd_next.v      = it.v;
        crd_next.pole   = it.pole;
        crd_next.hand   = it.hand;
    end

    logic [NSTG:0] cr_vld_reg;
    crd_t          cr_reg [NSTG+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cr_vld_reg[0] <= 1'b0;
        else
            cr_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        cr_reg[0] <= crd_next;
    end

    for (genvar i = 0; i < NSTG; i++)
    begin : g_cordic
        crd_t step;
        always_comb
        begin
            step   = cr_reg[i];
            step.a = cordic_step(cr_reg[i].a, i);
            step.b = cordic_step(cr_reg[i].b, i);
            step.c = cordic_step(cr_reg[i].c, i);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cr_vld_reg[i+1] <= 1'b0;
            else
                cr_vld_reg[i+1] <= cr_vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            cr_reg[i+1] <= step;
        end
    end

    // output stage: round, special cases, angle order
    crd_t               fin;
    logic signed [15:0] ang_a;
    logic signed [15:0] ang_b;
    logic signed [15:0] ang_c;
    logic signed [15:0] half;
    logic signed [15:0] first_next;
    logic signed [15:0] second_next;
    logic signed [15:0] third_next;

    assign fin = cr_reg[NSTG];

    always_comb
    begin
        ang_a = fin.zero_a ? 16'sd0 : round_angle(fin.a.z);
        ang_c = fin.zero_c ? 16'sd0 : round_angle(fin.c.z);
        if (fin.sat)
            ang_b = fin.v[15] ? -HALF_PI_Q13 : HALF_PI_Q13;
        else
            ang_b = round_angle(fin.b.z);
        half = (fin.pole == POLE_NORTH) ? HALF_PI_Q13 : -HALF_PI_Q13;
        priority if (fin.pole != POLE_NONE && !fin.hand)
        begin
            first_next  = ang_a;
            second_next = half;
            third_next  = 16'sd0;
        end
        else if (fin.pole != POLE_NONE)
        begin
            first_next  = 16'sd0;
            second_next = ang_a;
            third_next  = half;
        end
        else if (!fin.hand)
        begin
            first_next  = ang_a;
            second_next = ang_b;
            third_next  = ang_c;
        end
        else
        begin
            first_next  = -ang_c;
            second_next = ang_a;
            third_next  = ang_b;
        end
    end

    logic done_reg;
    logic signed [15:0] first_reg;
    logic signed [15:0] second_reg;
    logic signed [15:0] third_reg;
    logic [1:0]         pole_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cr_vld_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
        third_reg  <= third_next;
        pole_reg   <= fin.pole;
    end

    assign done         = done_reg;
    assign angle_first  = first_reg;
    assign angle_second = second_reg;
    assign angle_third  = third_reg;
    assign pole_case    = pole_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result beat without matching start");

    a_pole_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pole_case != 2'd3))
        else $error("invalid pole code");

    a_pole_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pole_case != POLE_NONE) |->
            (angle_third == 16'sd0 || angle_first == 16'sd0))
        else $error("pole beat without zero angle");

endmodule

/* tb/rotation_matrix_to_euler_angles_core_test.sv */
// rotation_matrix_to_euler_angles_core_test: self-checking bench for the euler angle core
// drives matrices through the start handshake and checks every done beat
// against its own cordic predictor; depends on rmte_pkg and the core
`timescale 1ns / 100ps

module rotation_matrix_to_euler_angles_core_test;
    import rmte_pkg::*;

    localparam int STAGES    = 14;
    localparam int LATENCY   = 42;
    localparam int DRAIN     = LATENCY + 10;
    localparam longint PI_24 = 52707179;
    localparam longint PI_13 = 25736;

    typedef struct {
        logic signed [15:0] m11, m13, m21, m22, m23, m31, m33;
    } matrix_t;

    typedef struct {
        logic signed [15:0] first;
        logic signed [15:0] second;
        logic signed [15:0] third;
        logic [1:0]         pole;
    } angles_t;

    typedef struct {
        matrix_t m;
        bit      typed;
        angles_t e;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               wr_en = 1'b0;
    logic               wr_index = REG_HANDEDNESS;
    logic [14:0]        wr_data = '0;
    logic signed [15:0] m11 = '0, m13 = '0, m21 = '0, m22 = '0;
    logic signed [15:0] m23 = '0, m31 = '0, m33 = '0;
    logic               done;
    logic signed [15:0] angle_first, angle_second, angle_third;
    logic [1:0]         pole_case;

    bit          hand_cfg;
    logic [14:0] thr_cfg;
    angles_t     angle_q[$];
    int          errors;
    int          sent;
    int          checked;
    int          pole_seen;
    bit          no_gaps;

    rotation_matrix_to_euler_angles_core #(.CORDIC_STAGES(STAGES)) i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .m11(m11), .m13(m13), .m21(m21), .m22(m22), .m23(m23), .m31(m31), .m33(m33),
        .done(done), .angle_first(angle_first), .angle_second(angle_second),
        .angle_third(angle_third), .pole_case(pole_case)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic longint atan_q24(input int i);
        longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                          262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                          1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        return t[i];
    endfunction

    // vectoring cordic on q.24 operands, result rounded to q2.13
    function automatic logic signed [15:0] vector_angle(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        int     n;
        z = 0;
        n = (STAGES > 24) ? 24 : STAGES;
        if (x == 0 && y == 0)
            return '0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_24 : -PI_24;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < n; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_q24(i);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_q24(i);
            end
        end
        z = (z + 1024) >>> 11;
        if (z > PI_13)
            z = PI_13;
        if (z < -PI_13)
            z = -PI_13;
        return z[15:0];
    endfunction

    function automatic longint floor_sqrt(input longint n);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] pitch_from(input longint v);
        if (v >= 16384)
            return HALF_PI_Q13;
        if (v <= -16384)
            return -HALF_PI_Q13;
        return vector_angle(v * 1024, floor_sqrt((268435456 - v * v) << 20));
    endfunction

    function automatic angles_t euler_from_matrix(input matrix_t m);
        angles_t     a;
        longint      thr;
        longint      v;
        logic signed [15:0] lock, half, yaw, pitch, roll;
        thr = thr_cfg;
        v = m.m21;
        if (v > thr || v < -thr)
        begin
            lock   = vector_angle(longint'(m.m13) * 1024, longint'(m.m33) * 1024);
            half   = (v > thr) ? HALF_PI_Q13 : -HALF_PI_Q13;
            a.pole = (v > thr) ? POLE_NORTH : POLE_SOUTH;
            if (!hand_cfg)
            begin
                a.first = lock; a.second = half; a.third = '0;
            end
            else
            begin
                a.first = '0; a.second = lock; a.third = half;
            end
        end
        else
        begin
            yaw    = vector_angle(-longint'(m.m31) * 1024, longint'(m.m11) * 1024);
            pitch  = pitch_from(v);
            roll   = vector_angle(-longint'(m.m23) * 1024, longint'(m.m22) * 1024);
            a.pole = POLE_NONE;
            if (!hand_cfg)
            begin
                a.first = yaw; a.second = pitch; a.third = roll;
            end
            else
            begin
                a.first = -roll; a.second = yaw; a.third = pitch;
            end
        end
        return a;
    endfunction

    // drive one matrix after a random gap (none when no_gaps is set), return once the beat is taken
    task automatic send_matrix(input matrix_t m, input bit typed, input angles_t e);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        m11 <= m.m11; m13 <= m.m13; m21 <= m.m21; m22 <= m.m22;
        m23 <= m.m23; m31 <= m.m31; m33 <= m.m33;
        do
            @(posedge clk);
        while (busy);
        angle_q.push_back(typed ? e : euler_from_matrix(m));
        sent++;
    endtask

    // one write beat, then wr_en is low again before the task returns
    task automatic write_reg(input logic idx, input logic [14:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en    <= 1'b0;
        if (idx == REG_HANDEDNESS)
            hand_cfg = val[0];
        else
            thr_cfg = val;
        @(posedge clk);
    endtask

    // let the pipe empty before touching the registers
    task automatic settle();
        start <= 1'b0;
        while (angle_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_elem(input logic signed [15:0] lim);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 16'($urandom_range(0, 2 * lim) - lim);
        else if (r < 8)
            return 16'($urandom());
        else
            return r[0] ? 16'sh7fff : 16'sh8000;
    endfunction

    always @(posedge clk)
    begin
        angles_t e;
        if (rst_n && done)
        begin
            if (angle_q.size() == 0)
            begin
                $error("done beat with no matrix outstanding");
                errors++;
            end
            else
            begin
                e = angle_q.pop_front();
                checked++;
                if (pole_case != POLE_NONE)
                    pole_seen++;
                if (angle_first !== e.first)
                begin
                    $error("angle_first expected %0d got %0d", e.first, angle_first);
                    errors++;
                end
                if (angle_second !== e.second)
                begin
                    $error("angle_second expected %0d got %0d", e.second, angle_second);
                    errors++;
                end
                if (angle_third !== e.third)
                begin
                    $error("angle_third expected %0d got %0d", e.third, angle_third);
                    errors++;
                end
                if (pole_case !== e.pole)
                begin
                    $error("pole_case expected %0d got %0d", e.pole, pole_case);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2ms;
        $display("rotation_matrix_to_euler_angles_core verification failed");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        matrix_t   m;
        angles_t   none;
        int        hands[7] = '{1, 0, 1, 0, 1, 0, 1};
        int        thrs[7]  = '{16351, 0, 16384, 32767, 0, 12000, 16000};
        int        phase_thr;
        int        near;

        none = '{default: '0};
        hand_cfg = 1'b0;
        thr_cfg  = THRESHOLD_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, reset configuration; typed rows are gimbal lock with zero lock angle
        row = '{m: '{default: '0}, typed: 1'b1,
                e: '{16'sd0, HALF_PI_Q13, 16'sd0, POLE_NORTH}};
        row.m.m21 = 16'sh7fff;
        rows.push_back(row);
        row.m.m21 = 16'sh8000;
        row.e = '{16'sd0, -HALF_PI_Q13, 16'sd0, POLE_SOUTH};
        rows.push_back(row);
        row.m.m21 = 16'sd16352;
        row.e = '{16'sd0, HALF_PI_Q13, 16'sd0, POLE_NORTH};
        rows.push_back(row);
        row.typed = 1'b0;
        row.e = none;
        row.m = '{default: '0};
        rows.push_back(row);
        row.m = '{default: 16'sh7fff};
        rows.push_back(row);
        row.m = '{default: 16'sh8000};
        rows.push_back(row);
        row.m = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sh8000, 16'sh7fff,
                  16'sh8000, 16'sh7fff};
        rows.push_back(row);
        row.m = '{16'sd16384, 16'sd0, 16'sd16351, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384};
        rows.push_back(row);
        row.m.m21 = -16'sd16351;
        rows.push_back(row);
        row.m = '{-16'sd16384, 16'sd100, 16'sd0, -16'sd16384, -16'sd5, -16'sd5, 16'sd0};
        rows.push_back(row);
        row.m = '{-16'sd16384, -16'sd100, 16'sd8192, -16'sd3, 16'sd5, 16'sd5, -16'sd9};
        rows.push_back(row);
        row.m = '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 16'sd1, 16'sd0};
        rows.push_back(row);
        row.m = '{16'sd11585, -16'sd9000, 16'sd20000, 16'sd11585, 16'sd0, 16'sd0, -16'sd200};
        rows.push_back(row);
        row.m = '{16'sd11585, -16'sd9000, -16'sd20000, 16'sd11585, 16'sd0, 16'sd0, -16'sd200};
        rows.push_back(row);
        row.m = '{16'sd0, 16'sd0, 16'sd16351, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        rows.push_back(row);

        foreach (rows[i])
        begin
            no_gaps = (i < 5);
            send_matrix(rows[i].m, rows[i].typed, rows[i].e);
        end

        // random phases, each with its own register setting
        for (int p = 0; p < 7; p++)
        begin
            settle();
            phase_thr = (p == 6) ? $urandom_range(0, 16384) : thrs[p];
            write_reg(REG_HANDEDNESS, 15'(hands[p]));
            write_reg(REG_THRESHOLD, 15'(phase_thr));
            no_gaps = 1'b0;
            for (int k = 0; k < 90; k++)
            begin
                if (k % 30 == 0)
                    no_gaps = ($urandom_range(0, 2) == 0);
                m.m11 = rand_elem(16'sd16384);
                m.m13 = rand_elem(16'sd16384);
                m.m22 = rand_elem(16'sd16384);
                m.m23 = rand_elem(16'sd16384);
                m.m31 = rand_elem(16'sd16384);
                m.m33 = rand_elem(16'sd16384);
                near = $urandom_range(0, 3);
                if (near == 0)
                    m.m21 = 16'($urandom_range(0, 8) - 4 + phase_thr);
                else if (near == 1)
                    m.m21 = 16'(-phase_thr + $urandom_range(0, 8) - 4);
                else
                    m.m21 = rand_elem(16'sd16384);
                send_matrix(m, 1'b0, none);
            end
        end

        settle();
        $display("sent %0d matrices over 8 register settings, checked %0d beats", sent, checked);
        $display("%0d beats took the gimbal lock path", pole_seen);
        if (errors == 0 && angle_q.size() == 0)
            $display("rotation_matrix_to_euler_angles_core verification clean");
        else
            $display("rotation_matrix_to_euler_angles_core verification failed");
        $finish;
    end

endmodule
